// File: rtl/core/fqs_pkg.sv
package fqs_pkg;

    // Default geometry of the queue.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 5;

    // Commands carried by a request item.
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_DEQUEUE  = 2'd1,
        CMD_PEEK     = 2'd2,
        CMD_CONTAINS = 2'd3
    } cmd_t;

    // Status codes carried by a response item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Per-cell storage control issued by the queue controller.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// File: rtl/core/fqs_if.sv
// Request channel: one command and its operand per item.
interface fqs_req_if import fqs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    cmd_t                       command;
    logic signed [FIELD_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// Response channel: one result per accepted request item.
interface fqs_rsp_if import fqs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    status_t                    status;
    logic signed [FIELD_W-1:0]  data;
    logic [COUNT_W-1:0]         count;
    logic                       empty_res;

    modport source (output valid, output status, output data, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input status, input data, input count,
                    input empty_res, output ready);
endinterface

// File: rtl/core/fqs_cell.sv
module fqs_cell import fqs_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cell_ctl_t                    ctl,
    input  logic                         occupied,
    input  logic signed [DATA_WIDTH-1:0] wr_data,
    input  logic signed [DATA_WIDTH-1:0] nb_data,
    output logic signed [DATA_WIDTH-1:0] cell_value,
    input  logic                         srch_vld_prev,
    input  logic                         srch_hit_prev,
    input  logic signed [DATA_WIDTH-1:0] srch_key_prev,
    output logic                         srch_vld,
    output logic                         srch_hit,
    output logic signed [DATA_WIDTH-1:0] srch_key
);

    logic signed [DATA_WIDTH-1:0] val_reg;
    logic signed [DATA_WIDTH-1:0] val_next;
    logic                         srch_vld_reg;
    logic                         srch_hit_reg;
    logic                         srch_hit_next;
    logic signed [DATA_WIDTH-1:0] srch_key_reg;

    // Storage: an enqueue writes this cell, a dequeue pulls the value
    // of the neighbor behind it toward the head.
    always_comb
    begin
        val_next = val_reg;
        if (ctl.load)
        begin
            val_next = wr_data;
        end
        else if (ctl.shift)
        begin
            val_next = nb_data;
        end
    end

    // The search key passes by one cell per cycle and picks up a hit
    // when this cell holds a live entry equal to it.
    assign srch_hit_next = srch_hit_prev | (occupied && (val_reg == srch_key_prev));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_vld_reg <= 1'b0;
        end
        else
        begin
            srch_vld_reg <= srch_vld_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        srch_hit_reg <= srch_hit_next;
        srch_key_reg <= srch_key_prev;
    end

    assign cell_value = val_reg;
    assign srch_vld   = srch_vld_reg;
    assign srch_hit   = srch_hit_reg;
    assign srch_key   = srch_key_reg;

endmodule

// File: rtl/core/fifo_queue_with_search.sv
// Enqueue, dequeue and peek: result registered in the cycle after the item is
// accepted; one item per cycle while the response side keeps taking results.
// Contains: result registered once the search key has walked the chain of DEPTH
// cells, one cell per cycle; no item is taken meanwhile.
// Reset clears occupancy, busy, the search valid bits and the result valid flag;
// cell storage is not cleared, since only occupied cells are ever read or matched.
module fifo_queue_with_search import fqs_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fqs_req_if.sink   req,
    fqs_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         accept;
    logic                         full;
    logic                         empty;
    logic signed [DATA_WIDTH-1:0] key;

    logic [CNT_W-1:0]             occ_reg;
    logic [CNT_W-1:0]             occ_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    status_t                      status_reg;
    status_t                      status_next;
    logic signed [FIELD_W-1:0]    data_reg;
    logic signed [FIELD_W-1:0]    data_next;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_next;
    logic                         empty_reg;
    logic                         empty_next;

    logic signed [DATA_WIDTH-1:0] cell_val [DEPTH];
    logic [DEPTH:0]               srch_vld;
    logic [DEPTH:0]               srch_hit;
    logic signed [DATA_WIDTH-1:0] srch_key [DEPTH+1];

    // Handshake: a new item waits for the search to finish and for room
    // in the output register.
    assign req.ready = !busy_reg && (!out_vld_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign key       = DATA_WIDTH'(req.value);

    // A contains command launches the key into the head of the chain.
    assign srch_vld[0] = accept && (req.command == CMD_CONTAINS);
    assign srch_hit[0] = 1'b0;
    assign srch_key[0] = key;

    // Chain of storage cells, cell 0 holding the head of the queue.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctl_t                    ctl;
        logic                         occupied;
        logic signed [DATA_WIDTH-1:0] nb_data;

        assign ctl.shift = accept && (req.command == CMD_DEQUEUE) && !empty;
        assign ctl.load  = accept && (req.command == CMD_ENQUEUE) && !full
                           && (occ_reg == CNT_W'(i));
        assign occupied  = (CNT_W'(i) < occ_reg);

        if (i < DEPTH - 1)
        begin : g_inner
            assign nb_data = cell_val[i+1];
        end
        else
        begin : g_last
            assign nb_data = cell_val[i];
        end

        fqs_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .occupied      (occupied),
            .wr_data       (key),
            .nb_data       (nb_data),
            .cell_value    (cell_val[i]),
            .srch_vld_prev (srch_vld[i]),
            .srch_hit_prev (srch_hit[i]),
            .srch_key_prev (srch_key[i]),
            .srch_vld      (srch_vld[i+1]),
            .srch_hit      (srch_hit[i+1]),
            .srch_key      (srch_key[i+1])
        );
    end

    // Command decode, occupancy update and the result register.
    always_comb
    begin
        occ_next     = occ_reg;
        busy_next    = busy_reg;
        out_vld_next = out_vld_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        count_next   = count_reg;
        empty_next   = empty_reg;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (srch_vld[DEPTH])
        begin
            busy_next    = 1'b0;
            out_vld_next = 1'b1;
            status_next  = srch_hit[DEPTH] ? ST_OK : ST_MISS;
            data_next    = '0;
            count_next   = COUNT_W'(occ_reg);
            empty_next   = empty;
        end
        else if (accept)
        begin
            status_next = ST_OK;
            data_next   = '0;
            unique case (req.command)
                CMD_ENQUEUE:
                begin
                    out_vld_next = 1'b1;
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                CMD_DEQUEUE:
                begin
                    out_vld_next = 1'b1;
                    if (empty)
                    begin
                        status_next = ST_MISS;
                    end
                    else
                    begin
                        data_next = FIELD_W'(cell_val[0]);
                        occ_next  = occ_reg - CNT_W'(1);
                    end
                end
                CMD_PEEK:
                begin
                    out_vld_next = 1'b1;
                    if (empty)
                    begin
                        status_next = ST_MISS;
                    end
                    else
                    begin
                        data_next = FIELD_W'(cell_val[0]);
                    end
                end
                CMD_CONTAINS:
                begin
                    busy_next = 1'b1;
                end
            endcase
            count_next = COUNT_W'(occ_next);
            empty_next = (occ_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            occ_reg     <= occ_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
        empty_reg  <= empty_next;
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.status    = status_reg;
    assign rsp.data      = data_reg;
    assign rsp.count     = count_reg;
    assign rsp.empty_res = empty_reg;

    // Occupancy never exceeds the number of cells.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // Only one search key travels the chain at a time.
    a_one_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(srch_vld))
        else $error("more than one search in flight");

    // The busy flag tracks exactly the key in the chain.
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (|srch_vld[DEPTH:1]))
        else $error("busy flag out of step with search chain");

    // The queue contents do not move while a search is running.
    a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(occ_reg))
        else $error("occupancy changed during search");

    // A new result only appears after an accepted item or a finished search.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> ($past(accept) || $past(srch_vld[DEPTH])))
        else $error("result produced without a cause");

endmodule
